>>> src/wml_pkg.sv
// ----------------------------------------------------------------------------
// Window median by lightness: shared package
// Holds the widths, the beat types of both channels and the window limits.
// ----------------------------------------------------------------------------
package wml_pkg;

	localparam int MAX_PIX   = 9;
	localparam int PIX_W     = 24;
	localparam int LUM_W     = 8;
	localparam int IDX_W     = 4;
	localparam int RANK_W    = 4;
	localparam int DEF_WIN_W = 3;
	localparam int DEF_WIN_H = 3;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [LUM_W-1:0]  lum_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [RANK_W-1:0] rank_t;

	typedef struct packed {
		pix_t pixel_0;
		pix_t pixel_1;
		pix_t pixel_2;
		pix_t pixel_3;
		pix_t pixel_4;
		pix_t pixel_5;
		pix_t pixel_6;
		pix_t pixel_7;
		pix_t pixel_8;
	} in_beat_t;

	typedef struct packed {
		pix_t median_pixel;
		lum_t median_lightness;
		idx_t median_index;
	} out_beat_t;

endpackage

>>> src/wml_light.sv
// ----------------------------------------------------------------------------
// Window median by lightness: lightness lane
// Computes (max + min) / 2 of the three color channels of one pixel.
// ----------------------------------------------------------------------------
module wml_light
	import wml_pkg::*;
(
	input  pix_t pixel,
	output lum_t lightness
);

	logic [7:0] r;
	logic [7:0] g;
	logic [7:0] b;
	logic [7:0] hi;
	logic [7:0] lo;
	logic [8:0] sum;

	always_comb begin
		r = pixel[23:16];
		g = pixel[15:8];
		b = pixel[7:0];
		hi = r;
		lo = r;
		if (g > hi) begin
			hi = g;
		end
		if (b > hi) begin
			hi = b;
		end
		if (g < lo) begin
			lo = g;
		end
		if (b < lo) begin
			lo = b;
		end
		sum = {1'b0, hi} + {1'b0, lo};
	end

	assign lightness = sum[8:1];

endmodule

>>> src/wml_rank.sv
// ----------------------------------------------------------------------------
// Window median by lightness: rank lane
// Counts the pixels that sort ahead of this lane's pixel, brighter first and
// the lower window index first among equals.
// ----------------------------------------------------------------------------
module wml_rank
	import wml_pkg::*;
#(
	parameter int NUM_PIX = MAX_PIX,
	parameter int LANE    = 0
) (
	input  lum_t  lum [MAX_PIX],
	output rank_t rank
);

	logic [MAX_PIX-1:0] ahead;

	always_comb begin
		for (int q = 0; q < MAX_PIX; q++) begin
			if (q < NUM_PIX) begin
				ahead[q] = (lum[q] > lum[LANE]) || ((lum[q] == lum[LANE]) && (q < LANE));
			end else begin
				ahead[q] = 1'b0;
			end
		end
	end

	assign rank = RANK_W'($countones(ahead));

endmodule

>>> src/wml_merge.sv
// ----------------------------------------------------------------------------
// Window median by lightness: merge stage
// Picks the one lane whose rank equals the middle rank of the window.
// ----------------------------------------------------------------------------
module wml_merge
	import wml_pkg::*;
#(
	parameter int NUM_PIX = MAX_PIX
) (
	input  pix_t      pix  [MAX_PIX],
	input  lum_t      lum  [MAX_PIX],
	input  rank_t     rank [MAX_PIX],
	output out_beat_t result
);

	localparam int    Target    = NUM_PIX / 2;
	localparam rank_t TargetRank = RANK_W'(Target);

	logic [MAX_PIX-1:0] hit;

	always_comb begin
		result = '0;
		for (int p = 0; p < MAX_PIX; p++) begin
			hit[p] = (p < NUM_PIX) && (rank[p] == TargetRank);
			if (hit[p]) begin
				result.median_pixel     = result.median_pixel | pix[p];
				result.median_lightness = result.median_lightness | lum[p];
				result.median_index     = result.median_index | IDX_W'(p);
			end
		end
	end

endmodule

>>> src/window_median_by_lightness_top.sv
// ----------------------------------------------------------------------------
// Window median by lightness: top level
// Returns the pixel of a window that holds the median lightness rank.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one window per beat,
// pixels packed 0xRRGGBB in column-major order. The output channel (out_valid,
// out_ready, out_data) returns one beat per window: the color, lightness and
// window index of the pixel at the middle rank, ranked by lightness from
// brightest down and by lower index among equal lightness.
// The pipeline has three register stages: lightness lanes, rank lanes and the
// merge into the output register. One window is taken every cycle while the
// receiver keeps up. When the receiver stalls, the stages fill up one by one
// and in_ready falls only once every stage holds a beat; no beat is dropped.
// Reset clears all valid flags, so the block starts empty with in_ready high.
// The window size follows WIN_W * WIN_H; only the first pixels of a beat that
// fall inside that count take part.
// ----------------------------------------------------------------------------
module window_median_by_lightness_top
	import wml_pkg::*;
#(
	parameter int WIN_W = DEF_WIN_W,
	parameter int WIN_H = DEF_WIN_H
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int NumRaw = WIN_W * WIN_H;
	localparam int NumPix = (NumRaw < 1) ? 1 : ((NumRaw > MAX_PIX) ? MAX_PIX : NumRaw);

	pix_t      pix_in [MAX_PIX];
	lum_t      lum_in [MAX_PIX];
	pix_t      pix_s1 [MAX_PIX];
	lum_t      lum_s1 [MAX_PIX];
	rank_t     rank_c [MAX_PIX];
	pix_t      pix_s2 [MAX_PIX];
	lum_t      lum_s2 [MAX_PIX];
	rank_t     rank_s2 [MAX_PIX];
	out_beat_t merged;

	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic rdy1;
	logic rdy2;
	logic rdy3;

	assign pix_in[0] = in_data.pixel_0;
	assign pix_in[1] = in_data.pixel_1;
	assign pix_in[2] = in_data.pixel_2;
	assign pix_in[3] = in_data.pixel_3;
	assign pix_in[4] = in_data.pixel_4;
	assign pix_in[5] = in_data.pixel_5;
	assign pix_in[6] = in_data.pixel_6;
	assign pix_in[7] = in_data.pixel_7;
	assign pix_in[8] = in_data.pixel_8;

	for (genvar k = 0; k < MAX_PIX; k++) begin : g_lane
		wml_light u_light (
			.pixel     (pix_in[k]),
			.lightness (lum_in[k])
		);

		wml_rank #(
			.NUM_PIX (NumPix),
			.LANE    (k)
		) u_rank (
			.lum  (lum_s1),
			.rank (rank_c[k])
		);
	end

	wml_merge #(
		.NUM_PIX (NumPix)
	) u_merge (
		.pix    (pix_s2),
		.lum    (lum_s2),
		.rank   (rank_s2),
		.result (merged)
	);

	assign rdy3     = !out_valid_q || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			pix_s1 <= pix_in;
			lum_s1 <= lum_in;
		end
		if (valid_s1 && rdy2) begin
			pix_s2  <= pix_s1;
			lum_s2  <= lum_s1;
			rank_s2 <= rank_c;
		end
		if (valid_s2 && rdy3) begin
			out_data <= merged;
		end
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Window median by lightness: testbench
// Sends 3x3 windows through the block, first a short table of corner cases and
// then random windows built to produce many lightness ties. Every result beat
// is checked field by field against the testbench model of the median rank,
// or for two table entries against a result stored in the table. Both sides
// stall at random; once, the receiver holds off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module testbench;
	import wml_pkg::*;

	localparam int WIN_W       = DEF_WIN_W;
	localparam int WIN_H       = DEF_WIN_H;
	localparam int WIN_N       = (WIN_W * WIN_H < 1) ? 1 :
		(WIN_W * WIN_H > MAX_PIX) ? MAX_PIX : WIN_W * WIN_H;
	localparam int PLAN_N      = 12;
	localparam int RANDOM_N    = 590;
	localparam int TOTAL_N     = PLAN_N + RANDOM_N;
	localparam int CALM_N      = 60;
	localparam int SQUEEZE_AT  = 150;
	localparam int SQUEEZE_LEN = 160;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		in_beat_t  win;
		logic      known;
		out_beat_t res;
	} vector_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	out_beat_t offered_medians [$];
	out_beat_t due_medians [$];
	out_beat_t want;
	int        windows_in = 0;
	int        quiet_cycles = 0;
	int        mismatches = 0;

	window_median_by_lightness_top #(
		.WIN_W(WIN_W),
		.WIN_H(WIN_H)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	function automatic pix_t pixel_at(in_beat_t w, int k);
		return w[(MAX_PIX - 1 - k) * PIX_W +: PIX_W];
	endfunction

	function automatic lum_t hsl_lightness(pix_t c);
		logic [7:0] r, g, b, hi, lo;
		logic [8:0] sum;
		r = c[23:16];
		g = c[15:8];
		b = c[7:0];
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		sum = {1'b0, hi} + {1'b0, lo};
		return sum[8:1];
	endfunction

	function automatic out_beat_t median_by_lightness(in_beat_t w);
		lum_t      l [MAX_PIX];
		int        rank;
		int        pick;
		out_beat_t r;
		pick = 0;
		for (int p = 0; p < WIN_N; p++) l[p] = hsl_lightness(pixel_at(w, p));
		for (int p = 0; p < WIN_N; p++) begin
			rank = 0;
			for (int q = 0; q < WIN_N; q++) begin
				if (l[q] > l[p] || (l[q] == l[p] && q < p)) rank++;
			end
			if (rank == WIN_N / 2) pick = p;
		end
		r.median_pixel     = pixel_at(w, pick);
		r.median_lightness = l[pick];
		r.median_index     = idx_t'(pick);
		return r;
	endfunction

	// A color whose brightest and darkest channels are hi and lo, in random order.
	function automatic pix_t tone(int hi, int lo);
		logic [7:0] ch [3];
		logic [7:0] t;
		int         a, b;
		ch[0] = 8'(hi);
		ch[1] = 8'(lo);
		ch[2] = 8'($urandom_range(hi, lo));
		repeat (3) begin
			a = $urandom_range(0, 2);
			b = $urandom_range(0, 2);
			t = ch[a];
			ch[a] = ch[b];
			ch[b] = t;
		end
		return {ch[0], ch[1], ch[2]};
	endfunction

	function automatic in_beat_t random_window();
		in_beat_t w;
		pix_t     px;
		int       mode, lvl, lo, j, v;
		int       his [3];
		int       los [3];
		mode = $urandom_range(0, 99);
		lvl  = $urandom_range(0, 254);
		for (int i = 0; i < 3; i++) begin
			his[i] = $urandom_range(0, 255);
			los[i] = $urandom_range(0, his[i]);
		end
		for (int k = 0; k < MAX_PIX; k++) begin
			v = $urandom;
			if (mode < 20) begin
				px = v[23:0];
			end else if (mode < 55) begin
				j  = $urandom_range(0, 2);
				px = tone(his[j], los[j]);
			end else if (mode < 75) begin
				px = {{8{v[0]}} ^ {v[1], 6'b0, v[2]},
					{8{v[3]}} ^ {v[4], 6'b0, v[5]},
					{8{v[6]}} ^ {v[7], 6'b0, v[8]}};
			end else begin
				lo = $urandom_range((2 * lvl + 1 > 255) ? 2 * lvl + 1 - 255 : 0, lvl);
				px = tone(2 * lvl - lo + v[0], lo);
			end
			w[(MAX_PIX - 1 - k) * PIX_W +: PIX_W] = px;
		end
		return w;
	endfunction

	initial begin
		vector_t  plan [PLAN_N];
		in_beat_t item;
		int       gap;
		in_valid = 1'b0;
		in_data  = '0;
		plan[0]  = '{win: '0, known: 1'b1, res: '{24'h000000, 8'h00, 4'd4}};
		plan[1]  = '{win: '1, known: 1'b1, res: '{24'hFFFFFF, 8'hFF, 4'd4}};
		plan[2]  = '{win: '{24'h000000, 24'h101010, 24'h202020, 24'h303030, 24'h404040,
			24'h505050, 24'h606060, 24'h707070, 24'h808080}, known: 1'b0, res: '0};
		plan[3]  = '{win: '{24'h808080, 24'h707070, 24'h606060, 24'h505050, 24'h404040,
			24'h303030, 24'h202020, 24'h101010, 24'h000000}, known: 1'b0, res: '0};
		plan[4]  = '{win: '{24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
			24'h000000, 24'h000000, 24'h000000, 24'h000000}, known: 1'b0, res: '0};
		plan[5]  = '{win: '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
			24'hFF00FF, 24'h7F7F7F, 24'h808080, 24'h000000}, known: 1'b0, res: '0};
		plan[6]  = '{win: '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
			24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA}, known: 1'b0, res: '0};
		plan[7]  = '{win: '{24'h010000, 24'h030000, 24'h000100, 24'h000003, 24'h020202,
			24'h010101, 24'h000002, 24'h030303, 24'h000000}, known: 1'b0, res: '0};
		plan[8]  = '{win: '{24'hFE00FF, 24'h7F7F7F, 24'h00FF00, 24'hFF0000, 24'h80807E,
			24'h0000FF, 24'h7E8080, 24'h40BF60, 24'hBF4020}, known: 1'b0, res: '0};
		plan[9]  = '{win: '{24'h800000, 24'h008000, 24'h000080, 24'h7FFFFF, 24'hFF7FFF,
			24'hFFFF7F, 24'h000001, 24'h000100, 24'h010000}, known: 1'b0, res: '0};
		plan[10] = '{win: '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
			24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF}, known: 1'b0, res: '0};
		plan[11] = '{win: '{24'h123456, 24'hFEDCBA, 24'h89ABCD, 24'h13579B, 24'hECA864,
			24'h2468AC, 24'hF0F0F0, 24'h0F0F0F, 24'h5A5A5A}, known: 1'b0, res: '0};
		wait (arst_n === 1'b1);
		for (int i = 0; i < TOTAL_N; i++) begin
			if (i < TOTAL_N - CALM_N && $urandom_range(0, 1) == 1) begin
				gap = $urandom_range(1, 16);
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			if (i < PLAN_N) begin
				item = plan[i].win;
				offered_medians.push_back(plan[i].known ? plan[i].res
					: median_by_lightness(item));
			end else begin
				item = random_window();
				offered_medians.push_back(median_by_lightness(item));
			end
			in_valid <= 1'b1;
			in_data  <= item;
			do @(posedge clk); while (!in_ready);
		end
		@(negedge clk) in_valid <= 1'b0;
		while (offered_medians.size() != 0 || due_medians.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		int len;
		bit squeezed;
		out_ready = 1'b0;
		squeezed  = 1'b0;
		wait (arst_n === 1'b1);
		while (windows_in < TOTAL_N - CALM_N) begin
			if (!squeezed && windows_in >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				@(negedge clk) out_ready <= 1'b0;
				repeat (SQUEEZE_LEN) @(negedge clk);
			end
			len = $urandom_range(1, 16);
			@(negedge clk) out_ready <= ($urandom_range(0, 2) != 0);
			repeat (len - 1) @(negedge clk);
		end
		@(negedge clk) out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				due_medians.push_back(offered_medians.pop_front());
				windows_in <= windows_in + 1;
			end
			if (out_valid && out_ready) begin
				if (due_medians.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result beat: %h", out_data);
				end else begin
					want = due_medians.pop_front();
					if (want.median_pixel !== out_data.median_pixel ||
						want.median_lightness !== out_data.median_lightness ||
						want.median_index !== out_data.median_index) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("median mismatch: pixel %h/%h lightness %h/%h index %0d/%0d",
								want.median_pixel, out_data.median_pixel,
								want.median_lightness, out_data.median_lightness,
								want.median_index, out_data.median_index);
					end
				end
			end
			quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0
				: quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

endmodule
